[sv/p2d_pkg.sv]
// Shared constants and types for the 2-D max/average pooling block.
`default_nettype none

package p2d_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 16;   // signed Q8.8 sample
    localparam int DIM_W      = 13;   // height / channel count register, also compare width
    localparam int WIDTH_W    = 9;    // frame width register
    localparam int WIN_W      = 3;    // window size / stride register
    localparam int AREA_W     = 6;    // window area, at most 7*7
    localparam int ROW_W      = 12;
    localparam int CHAN_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Largest frame height and channel count
    localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT   = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_CHANNELS = 3'd2,
        CFG_SIZE     = 3'd3,
        CFG_STRIDE   = 3'd4,
        CFG_MODE     = 3'd5
    } t_cfg_idx;

    // Pooling modes
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    // Register values after reset
    localparam logic [DIM_W-1:0]   RST_HEIGHT   = 13'd64;
    localparam logic [WIDTH_W-1:0] RST_WIDTH    = 9'd64;
    localparam logic [DIM_W-1:0]   RST_CHANNELS = 13'd16;
    localparam logic [WIN_W-1:0]   RST_SIZE     = 3'd2;
    localparam logic [WIN_W-1:0]   RST_STRIDE   = 3'd2;

endpackage

`default_nettype wire

[sv/pooling_2d_max_avg_top.sv]
// Top level of the 2-D max/average pooling block: line store, window sequencer, output register.
// A sample that completes no window leaves the sample side ready; one that does holds it
// off while the window is read through the single line-store read port (one window
// sample per cycle) and, in average mode, divided by the bit-serial divider. Reset is
// synchronous, active low; no clearing pass is needed.
`default_nettype none

module pooling_2d_max_avg_top #(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_POOL  = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [p2d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [p2d_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [p2d_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [p2d_pkg::SAMPLE_W-1:0]      o_pooled_value,
    output logic                                     o_frame_last
);

    import p2d_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int MEM_DEPTH = MAX_POOL * MAX_WIDTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SUM_W     = SAMPLE_W + $clog2(MAX_POOL * MAX_POOL);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_FIN,
        S_DIV,
        S_DONE
    } t_state;

    // Configuration registers
    logic [DIM_W-1:0]   r_cfg_height;
    logic [WIDTH_W-1:0] r_cfg_width;
    logic [DIM_W-1:0]   r_cfg_channels;
    logic [WIN_W-1:0]   r_cfg_size;
    logic [WIN_W-1:0]   r_cfg_stride;
    logic               r_cfg_mode;

    // Stream position
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [CHAN_W-1:0]  r_chan;
    logic [SLOT_W-1:0]  r_slot;
    logic [WIN_W-1:0]   r_rphase;   // (row + 1 - p) mod stride
    logic [WIN_W-1:0]   r_cphase;   // (col + 1 - p) mod stride

    // Window sequencer
    t_state             r_state;
    logic [SLOT_W-1:0]  r_rslot;
    logic [COL_W-1:0]   r_c0;
    logic [WIN_W-1:0]   r_i;
    logic [WIN_W-1:0]   r_j;
    logic               r_last;
    logic               r_rd_vld;
    logic               r_first;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_best;
    logic signed [SAMPLE_W-1:0] r_res;

    // Output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_value;
    logic                       r_out_last;

    // Line store
    logic signed [SAMPLE_W-1:0] r_line_store [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    // Combinational
    logic [DIM_W-1:0]    h_eff, w_eff, ch_eff, p13, s13, row13, col13, chan13;
    logic [WIN_W-1:0]    p_eff, s_eff;
    logic                in_xfer, out_xfer;
    logic                hit, last_win;
    logic                col_end, row_end, chan_end;
    logic [WIN_W-1:0]    cph_next, rph_next;
    logic [SLOT_W-1:0]   slot_inc, rslot_inc;
    logic [SLOT_W:0]     slot0_sum;
    logic [SLOT_W-1:0]   slot0;
    logic [COL_W-1:0]    c0, rd_col;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic                div_start, div_done;
    logic signed [SUM_W-1:0] div_quo;
    logic [AREA_W-1:0]   area;

    // Effective sizes: zero acts as one, oversized values clamp
    always_comb begin
        h_eff  = (r_cfg_height == '0) ? DIM_W'(1)
               : ((r_cfg_height > DIM_LIMIT) ? DIM_LIMIT : r_cfg_height);
        ch_eff = (r_cfg_channels == '0) ? DIM_W'(1)
               : ((r_cfg_channels > DIM_LIMIT) ? DIM_LIMIT : r_cfg_channels);
        w_eff  = (r_cfg_width == '0) ? DIM_W'(1)
               : ((DIM_W'(r_cfg_width) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                           : DIM_W'(r_cfg_width));
        p_eff  = (r_cfg_size == '0) ? WIN_W'(1)
               : (({1'b0, r_cfg_size} > (WIN_W+1)'(MAX_POOL)) ? WIN_W'(MAX_POOL)
                                                             : r_cfg_size);
        s_eff  = (r_cfg_stride == '0) ? WIN_W'(1) : r_cfg_stride;
        p13    = DIM_W'(p_eff);
        s13    = DIM_W'(s_eff);
        row13  = DIM_W'(r_row);
        col13  = DIM_W'(r_col);
        chan13 = DIM_W'(r_chan);
        area   = AREA_W'(p_eff) * AREA_W'(p_eff);
    end

    // Window completion and frame-end test for the sample at the current position
    always_comb begin
        hit = (p13 <= h_eff) && (p13 <= w_eff)
           && (row13 + DIM_W'(1) >= p13) && (col13 + DIM_W'(1) >= p13)
           && (r_rphase == '0) && (r_cphase == '0);
        // the origin is the last on the stride grid when one more stride would not fit
        last_win = (chan13 + DIM_W'(1) == ch_eff)
                && (row13 + s13 >= h_eff) && (col13 + s13 >= w_eff);
        col_end  = (col13 + DIM_W'(1) >= w_eff);
        row_end  = (row13 + DIM_W'(1) >= h_eff);
        chan_end = (chan13 + DIM_W'(1) >= ch_eff);
    end

    // Stride phase of the next column / row
    always_comb begin
        if (col13 + DIM_W'(2) <= p13) begin
            cph_next = '0;
        end else if ({1'b0, r_cphase} + (WIN_W+1)'(1) >= {1'b0, s_eff}) begin
            cph_next = '0;
        end else begin
            cph_next = r_cphase + 1'b1;
        end
        if (row13 + DIM_W'(2) <= p13) begin
            rph_next = '0;
        end else if ({1'b0, r_rphase} + (WIN_W+1)'(1) >= {1'b0, s_eff}) begin
            rph_next = '0;
        end else begin
            rph_next = r_rphase + 1'b1;
        end
    end

    // Line-store slot arithmetic, rows kept modulo MAX_POOL
    always_comb begin
        slot_inc  = (r_slot == SLOT_W'(MAX_POOL - 1)) ? '0 : r_slot + 1'b1;
        rslot_inc = (r_rslot == SLOT_W'(MAX_POOL - 1)) ? '0 : r_rslot + 1'b1;
        slot0_sum = (SLOT_W+1)'(r_slot) + (SLOT_W+1)'(MAX_POOL)
                  - (SLOT_W+1)'(p_eff - WIN_W'(1));
        slot0     = (slot0_sum >= (SLOT_W+1)'(MAX_POOL))
                  ? SLOT_W'(slot0_sum - (SLOT_W+1)'(MAX_POOL)) : SLOT_W'(slot0_sum);
        c0        = r_col - COL_W'(p_eff - WIN_W'(1));
        rd_col    = r_c0 + COL_W'(r_j);
        wr_addr   = ADDR_W'(r_slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(r_col);
        rd_addr   = ADDR_W'(r_rslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = r_out_valid && i_out_ready;
    assign div_start   = (r_state == S_FIN) && (r_cfg_mode == MODE_AVG);

    // Line store: write on sample transfer, registered read
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_line_store[wr_addr] <= i_sample;
        end
        r_rd_data <= r_line_store[rd_addr];
    end

    // Average: window sum divided by the window area
    p2d_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (AREA_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (area),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer, positions, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg_height   <= RST_HEIGHT;
            r_cfg_width    <= RST_WIDTH;
            r_cfg_channels <= RST_CHANNELS;
            r_cfg_size     <= RST_SIZE;
            r_cfg_stride   <= RST_STRIDE;
            r_cfg_mode     <= MODE_MAX;
            r_row          <= '0;
            r_col          <= '0;
            r_chan         <= '0;
            r_slot         <= '0;
            r_rphase       <= '0;
            r_cphase       <= '0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_i            <= '0;
            r_j            <= '0;
        end else begin
            r_rd_vld <= (r_state == S_READ);

            // accumulate the window sample read last cycle
            if (r_rd_vld) begin
                r_sum   <= r_sum + SUM_W'(r_rd_data);
                r_best  <= (r_first || (r_rd_data > r_best)) ? r_rd_data : r_best;
                r_first <= 1'b0;
            end

            // a transfer empties the output register unless a new result refills it
            if (out_xfer && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        // advance the raster position
                        if (col_end) begin
                            r_col    <= '0;
                            r_cphase <= '0;
                            if (row_end) begin
                                r_row    <= '0;
                                r_slot   <= '0;
                                r_rphase <= '0;
                                r_chan   <= chan_end ? '0 : r_chan + 1'b1;
                            end else begin
                                r_row    <= r_row + 1'b1;
                                r_slot   <= slot_inc;
                                r_rphase <= rph_next;
                            end
                        end else begin
                            r_col    <= r_col + 1'b1;
                            r_cphase <= cph_next;
                        end
                        if (hit) begin
                            r_rslot <= slot0;
                            r_c0    <= c0;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_last  <= last_win;
                            r_sum   <= '0;
                            r_first <= 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // one window sample per cycle, row by row
                    if (r_j == p_eff - WIN_W'(1)) begin
                        r_j <= '0;
                        if (r_i == p_eff - WIN_W'(1)) begin
                            r_state <= S_LAST;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_rslot <= rslot_inc;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_LAST: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_cfg_mode == MODE_AVG) begin
                        r_state <= S_DIV;
                    end else begin
                        r_res   <= r_best;
                        r_state <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= div_quo[SAMPLE_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res;
                        r_out_last  <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // a configuration write to a mapped index restarts the frame
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEIGHT:   r_cfg_height   <= i_cfg_data[DIM_W-1:0];
                    CFG_WIDTH:    r_cfg_width    <= i_cfg_data[WIDTH_W-1:0];
                    CFG_CHANNELS: r_cfg_channels <= i_cfg_data[DIM_W-1:0];
                    CFG_SIZE:     r_cfg_size     <= i_cfg_data[WIN_W-1:0];
                    CFG_STRIDE:   r_cfg_stride   <= i_cfg_data[WIN_W-1:0];
                    CFG_MODE:     r_cfg_mode     <= i_cfg_data[0];
                    default: ;
                endcase
                if ((i_cfg_index == CFG_HEIGHT) || (i_cfg_index == CFG_WIDTH)
                    || (i_cfg_index == CFG_CHANNELS) || (i_cfg_index == CFG_SIZE)
                    || (i_cfg_index == CFG_STRIDE) || (i_cfg_index == CFG_MODE)) begin
                    r_row    <= '0;
                    r_col    <= '0;
                    r_chan   <= '0;
                    r_slot   <= '0;
                    r_rphase <= '0;
                    r_cphase <= '0;
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pooled_value = r_out_value;
    assign o_frame_last   = r_out_last;

endmodule

`default_nettype wire

[sv/p2d_div.sv]
// Multi-cycle signed divider, restoring, one quotient bit per cycle, truncates toward zero.
`default_nettype none

module p2d_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [DIVIDEND_W-1:0] i_dividend,
    input  wire logic        [DIVISOR_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic signed      [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    rem_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {r_rem, r_quo[DIVIDEND_W-1]};
        fits     = (trial >= {1'b0, r_dvs});
        rem_diff = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[DIVIDEND_W-1];
                r_quo  <= i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend)
                                                   : DIVIDEND_W'(i_dividend);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? rem_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Restore the sign of the magnitude quotient
    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

[sv/p2d_chk.sv]
// Port-level checker for the pooling block and its bind to the top level.
`default_nettype none

module p2d_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic signed [p2d_pkg::SAMPLE_W-1:0] i_pooled_value,
    input wire logic                                i_frame_last
);

    import p2d_pkg::*;

    logic signed [SAMPLE_W-1:0] pooled_seen;
    assign pooled_seen = i_pooled_value;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(pooled_seen) && $stable(i_frame_last))
        else $error("result payload changed while stalled");

    // no result can appear in the cycle right after a sample transfer
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared too early after a sample transfer");

    // a new result is loaded only while the sample side is held off
    a_busy_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result loaded while sample side was ready");

endmodule

bind pooling_2d_max_avg_top p2d_chk u_p2d_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_ready     (o_in_ready),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_pooled_value (o_pooled_value),
    .i_frame_last   (o_frame_last)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the 2-D max/average pooling block.
`timescale 1ns / 1ps

module testbench;
    import p2d_pkg::*;

    localparam int MAX_WIDTH       = 256;
    localparam int MAX_POOL        = 4;
    localparam int SETTLE_CYCLES   = 64;      // longer than one window pass incl. divider
    localparam int OUT_HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int RUN_LIMIT_NS    = 10_000_000;
    localparam int RANDOM_TARGET   = 1320;    // running sample count where random frames stop

    // Index outside the register map, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } t_pooled;

    // DUT ports
    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [SAMPLE_W-1:0]  o_pooled_value;
    logic                        o_frame_last;

    // Shadow of the block: registers, positions and line store
    logic [DIM_W-1:0]            cfg_height;
    logic [WIDTH_W-1:0]          cfg_width;
    logic [DIM_W-1:0]            cfg_channels;
    logic [WIN_W-1:0]            cfg_size;
    logic [WIN_W-1:0]            cfg_stride;
    logic                        cfg_mode;
    int                          row_pos;
    int                          col_pos;
    int                          chan_pos;
    logic signed [SAMPLE_W-1:0]  line_mem [0:MAX_POOL*MAX_WIDTH-1];

    t_pooled                     pooled_due [$];
    int                          mismatch_count = 0;
    int                          samples_sent   = 0;
    bit                          no_gaps        = 1'b0;
    bit                          hold_out_req   = 1'b0;

    pooling_2d_max_avg_top #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_POOL  (MAX_POOL)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pooled_value (o_pooled_value),
        .o_frame_last   (o_frame_last)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Zero acts as one, values above the limit act as the limit
    function automatic int eff_dim(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Idle length for either side: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (no_gaps) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random sample with extra weight on the extremes
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic reset_shadow();
        cfg_height   = RST_HEIGHT;
        cfg_width    = RST_WIDTH;
        cfg_channels = RST_CHANNELS;
        cfg_size     = RST_SIZE;
        cfg_stride   = RST_STRIDE;
        cfg_mode     = MODE_MAX;
        row_pos      = 0;
        col_pos      = 0;
        chan_pos     = 0;
    endtask

    // Register write as seen by the block; a known index restarts the frame
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        bit known;
        known = 1'b1;
        case (index)
            CFG_HEIGHT:   cfg_height   = data[DIM_W-1:0];
            CFG_WIDTH:    cfg_width    = data[WIDTH_W-1:0];
            CFG_CHANNELS: cfg_channels = data[DIM_W-1:0];
            CFG_SIZE:     cfg_size     = data[WIN_W-1:0];
            CFG_STRIDE:   cfg_stride   = data[WIN_W-1:0];
            CFG_MODE:     cfg_mode     = data[0];
            default:      known        = 1'b0;
        endcase
        if (known) begin
            row_pos  = 0;
            col_pos  = 0;
            chan_pos = 0;
        end
    endtask

    // Store one sample, pool the window it completes (if any), step the raster position
    task automatic advance_pool(input logic signed [SAMPLE_W-1:0] sample);
        int      h, w, ch, p, s, r, c, r0, c0, i, j, v, sum, best;
        t_pooled item;
        h  = eff_dim(int'(cfg_height), int'(DIM_LIMIT));
        w  = eff_dim(int'(cfg_width), MAX_WIDTH);
        ch = eff_dim(int'(cfg_channels), int'(DIM_LIMIT));
        p  = eff_dim(int'(cfg_size), MAX_POOL);
        s  = (cfg_stride == 0) ? 1 : int'(cfg_stride);
        r  = row_pos;
        c  = col_pos;
        line_mem[(r % MAX_POOL) * MAX_WIDTH + (c % MAX_WIDTH)] = sample;

        if (p <= h && p <= w && r + 1 >= p && c + 1 >= p &&
            (r + 1 - p) % s == 0 && (c + 1 - p) % s == 0) begin
            r0   = r + 1 - p;
            c0   = c + 1 - p;
            sum  = 0;
            best = 0;
            for (i = 0; i < p; i++) begin
                for (j = 0; j < p; j++) begin
                    v = int'(line_mem[((r0 + i) % MAX_POOL) * MAX_WIDTH
                                      + ((c0 + j) % MAX_WIDTH)]);
                    sum += v;
                    if ((i == 0 && j == 0) || v > best) best = v;
                end
            end
            // signed int division truncates toward zero
            item.value = (cfg_mode == MODE_AVG) ? SAMPLE_W'(sum / (p * p)) : SAMPLE_W'(best);
            item.last  = (chan_pos + 1 == ch) && (r0 == ((h - p) / s) * s) &&
                         (c0 == ((w - p) / s) * s);
            pooled_due.push_back(item);
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            if (r + 1 >= h) begin
                row_pos  = 0;
                chan_pos = (chan_pos + 1 >= ch) ? 0 : chan_pos + 1;
            end else begin
                row_pos = r + 1;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    // One sample transfer; valid stays up across back-to-back samples
    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        advance_pool(value);
        samples_sent++;
    endtask

    // Drop valid, let every pending result come out, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pooled_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_reg(index, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // New frame geometry; every register is written
    task automatic set_frame(input logic [CFG_DATA_W-1:0] h, w, ch, p, s, m);
        wait_idle();
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_CHANNELS, ch);
        write_reg(CFG_SIZE, p);
        write_reg(CFG_STRIDE, s);
        write_reg(CFG_MODE, m);
    endtask

    // Max mode, extreme samples, frame of two windows
    task automatic test_max_extremes();
        set_frame(2, 4, 1, 2, 2, CFG_DATA_W'(MODE_MAX));
        offer_sample(16'sh8000);
        offer_sample(16'sh7FFF);
        offer_sample(-16'sd1);
        offer_sample(16'sh8000);
        offer_sample(16'sh8000);
        offer_sample(16'sh8000);
        offer_sample(16'sh8000);
        offer_sample(-16'sd256);
    endtask

    // Average of a 3x3 window with a negative sum: must truncate toward zero
    task automatic test_avg_truncation();
        int k;
        set_frame(3, 3, 1, 3, 1, CFG_DATA_W'(MODE_AVG));
        offer_sample(-16'sd5);
        for (k = 0; k < 8; k++) offer_sample(-16'sd1);
    endtask

    // Zero sizes, window larger than the frame, oversized values, unknown index
    task automatic test_special_sizes();
        set_frame(0, 0, 0, 0, 0, CFG_DATA_W'(MODE_AVG));
        offer_sample(16'sh8000);
        offer_sample(16'sh7FFF);

        set_frame(2, 5, 1, 3, 1, CFG_DATA_W'(MODE_MAX));
        offer_sample(16'sh1234);
        offer_sample(-16'sd77);
        offer_sample(16'sh7FFF);

        set_frame(13'h1FFF, 13'h1FF, 13'h1FFF, 7, 7, CFG_DATA_W'(MODE_MAX));
        offer_sample(16'sh0F0F);
        offer_sample(-16'sd3);

        // a write to an unmapped index must not restart the frame
        set_frame(1, 2, 1, 1, 1, CFG_DATA_W'(MODE_MAX));
        offer_sample(16'sh00AA);
        wait_idle();
        write_reg(CFG_SPARE, 13'h1555);
        offer_sample(16'shFF55);
    endtask

    // Receiver holds off for a long stretch while the sender keeps pushing
    task automatic test_output_stall();
        int k;
        set_frame(2, 3, 2, 1, 1, CFG_DATA_W'(MODE_MAX));
        no_gaps      = 1'b1;
        hold_out_req = 1'b1;
        for (k = 0; k < 30; k++) offer_sample(pick_sample());
        no_gaps = 1'b0;
    endtask

    // Largest height and channel count, line store slots wrap
    task automatic test_tall_frame();
        int k;
        set_frame(4096, 3, 4096, 3, 2, CFG_DATA_W'(MODE_AVG));
        for (k = 0; k < 36; k++) offer_sample(pick_sample());
    endtask

    // Widest rows, frame wraps into the next one
    task automatic test_wide_rows();
        int k;
        set_frame(1, MAX_WIDTH, 1, 1, 3, CFG_DATA_W'(MODE_MAX));
        for (k = 0; k < MAX_WIDTH + 4; k++) offer_sample(pick_sample());
    endtask

    // Random small frames, now and then a register at a raw random value
    task automatic test_random_frames(input int target);
        logic [CFG_DATA_W-1:0] h, w, ch, p, s, m;
        int                    n, k;
        while (samples_sent < target) begin
            p  = CFG_DATA_W'($urandom_range(1, MAX_POOL));
            h  = p + CFG_DATA_W'($urandom_range(0, 4));
            w  = p + CFG_DATA_W'($urandom_range(0, 8));
            ch = CFG_DATA_W'($urandom_range(1, 3));
            s  = CFG_DATA_W'($urandom_range(0, 7));
            m  = CFG_DATA_W'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: h = CFG_DATA_W'($urandom_range(0, 8191));
                1: w = CFG_DATA_W'($urandom_range(0, 511));
                2: ch = CFG_DATA_W'($urandom_range(0, 8191));
                3: p = CFG_DATA_W'($urandom_range(0, 7));
                4: begin
                    h = CFG_DATA_W'($urandom_range(0, 3));
                    w = CFG_DATA_W'($urandom_range(0, 3));
                end
                5: m = CFG_DATA_W'($urandom_range(0, 8191));
                default: ;
            endcase
            no_gaps = ($urandom_range(0, 4) == 0);
            set_frame(h, w, ch, p, s, m);
            n = $urandom_range(12, 60);
            for (k = 0; k < n; k++) offer_sample(pick_sample());
        end
        no_gaps = 1'b0;
    endtask

    // Result receiver: random ready, plus the long hold-off on request
    initial begin : result_sink
        int held;
        int wait_left;
        wait_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out_req) begin
                i_out_ready  <= 1'b0;
                hold_out_req  = 1'b0;
                for (held = 1; held < OUT_HOLD_CYCLES; held++) @(negedge i_clk);
            end else if (wait_left > 0) begin
                i_out_ready <= 1'b0;
                wait_left--;
            end else begin
                i_out_ready <= 1'b1;
                wait_left    = pick_gap();
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_pooled want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pooled_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual value %0d last %0b",
                         $time, o_pooled_value, o_frame_last);
                mismatch_count++;
            end else begin
                want = pooled_due.pop_front();
                if (o_pooled_value !== want.value) begin
                    $display("%0t: pooled_value mismatch: expected %0d, actual %0d",
                             $time, want.value, o_pooled_value);
                    mismatch_count++;
                end
                if (o_frame_last !== want.last) begin
                    $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                             $time, want.last, o_frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("testbench: done, errors");
        $finish;
    end

    // Test sequence
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        reset_shadow();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_max_extremes();
        test_avg_truncation();
        test_special_sizes();
        test_output_stall();
        test_tall_frame();
        test_wide_rows();
        test_random_frames(RANDOM_TARGET);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
